>>> rtl/psa_pkg.sv
// Shared types, codes and helpers for the pooled slot allocator.
// Used by psa_ctrl, psa_dpath and pooled_slot_allocator_with_id_lookup_core.
package psa_pkg;

    localparam int KEY_W = 64;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE  = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } psa_state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;    // write one cleared entry of the slot memory
        logic load;     // take the input item, restart the scan
        logic issue;    // read slot memory words while scanning
        logic capture;  // record the slot that matched
        logic commit;   // update state and load the output register
    } psa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic match;
        logic exhausted;
        logic out_free;
    } psa_stat_t;

    // Zero every byte after the first zero byte.
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (k[8*b +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                r[8*b +: 8] = k[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/pooled_slot_allocator_with_id_lookup_core.sv
// Pooled slot allocator with id lookup: POOLS pools of SLOTS_PER_POOL slots, each
// slot holding a busy bit and a 64-bit id in one single-port slot memory. After
// reset the block runs a clearing pass over every slot memory entry with s_tready
// low. Allocate, free and lookup scan the open pools one slot memory word per
// cycle, pool by pool, and stop at the first match. An unused command code skips
// the scan and reports not found. A new item is taken while the previous result
// waits in the output register. Ids are normalized on entry: bytes after the
// first zero byte are ignored. Pool and slot numbers in the result keep their
// low 4 bits.
// Depends on psa_pkg, psa_ctrl and psa_dpath.
module pooled_slot_allocator_with_id_lookup_core #(
    parameter int POOLS          = 16,
    parameter int SLOTS_PER_POOL = 16,
    parameter int INITIAL_POOLS  = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] slot_key
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [5:2] pool_number, [9:6] slot_number
);
    import psa_pkg::*;

    psa_cmd_t   cmd;
    psa_stat_t  stat;
    logic [1:0] out_status;
    logic [3:0] out_pool;
    logic [3:0] out_slot;

    psa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    psa_dpath #(
        .POOLS          (POOLS),
        .SLOTS_PER_POOL (SLOTS_PER_POOL),
        .INITIAL_POOLS  (INITIAL_POOLS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (s_tuser),
        .in_key     (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_pool   (out_pool),
        .out_slot   (out_slot)
    );

    assign m_tdata = {6'd0, out_slot, out_pool, out_status};

endmodule

>>> rtl/psa_ctrl.sv
// Controller for the pooled slot allocator: clearing pass, item intake,
// slot scan and commit sequencing. Depends on psa_pkg.
module psa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_tuser,
    input  psa_pkg::psa_stat_t  stat,
    output psa_pkg::psa_cmd_t   cmd
);
    import psa_pkg::*;

    psa_state_t state_reg;
    psa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    // unused command codes skip the scan and report not found
                    if (s_tuser inside {CMD_ALLOC, CMD_FREE, CMD_LOOKUP}) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (stat.match) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COMMIT;
                end else if (stat.exhausted) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/psa_dpath.sv
// Datapath for the pooled slot allocator: slot memory (busy bit and id),
// scan counters, open pool count and the output register. Depends on psa_pkg.
module psa_dpath #(
    parameter int POOLS          = 16,
    parameter int SLOTS_PER_POOL = 16,
    parameter int INITIAL_POOLS  = 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                in_cmd,
    input  logic [psa_pkg::KEY_W-1:0] in_key,
    input  psa_pkg::psa_cmd_t         cmd,
    output psa_pkg::psa_stat_t        stat,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [1:0]                out_status,
    output logic [3:0]                out_pool,
    output logic [3:0]                out_slot
);
    import psa_pkg::*;

    localparam int TOTAL     = POOLS * SLOTS_PER_POOL;
    localparam int AW        = $clog2(TOTAL);
    localparam int CW        = $clog2(TOTAL + 1);
    localparam int PW        = $clog2(POOLS + 1);
    localparam int SW        = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;
    localparam int INIT_OPEN = (INITIAL_POOLS > POOLS) ? POOLS : INITIAL_POOLS;
    localparam int WORD_W    = KEY_W + 1;

    // slot memory word: busy bit on top of the id
    logic [WORD_W-1:0] mem [TOTAL];

    logic [AW-1:0]      clr_cnt_reg;
    logic [PW-1:0]      pools_open_reg;
    logic [1:0]         cmd_reg;
    logic [KEY_W-1:0]   key_reg;

    logic [PW-1:0]      pool_cnt_reg;
    logic [SW-1:0]      slot_cnt_reg;
    logic [CW-1:0]      addr_reg;

    logic               rd_vld_reg;
    logic [WORD_W-1:0]  rd_word_reg;
    logic [PW-1:0]      rd_pool_reg;
    logic [SW-1:0]      rd_slot_reg;
    logic [AW-1:0]      rd_addr_reg;

    logic               hit_reg;
    logic [PW-1:0]      f_pool_reg;
    logic [SW-1:0]      f_slot_reg;
    logic [AW-1:0]      f_addr_reg;

    logic               m_tvalid_reg;
    logic [1:0]         out_status_reg;
    logic [3:0]         out_pool_reg;
    logic [3:0]         out_slot_reg;

    logic               do_issue;
    logic               match_now;
    logic               rd_busy;

    logic               wr_en;
    logic [AW-1:0]      wr_idx;
    logic [WORD_W-1:0]  wr_word;
    logic               c_wr;
    logic               c_open;
    logic [1:0]         c_status;
    logic [PW-1:0]      c_pool;
    logic [SW-1:0]      c_slot;
    logic [AW-1:0]      c_idx;
    logic [WORD_W-1:0]  c_word;
    logic [31:0]        pool_wide;
    logic [31:0]        slot_wide;

    assign rd_busy   = rd_word_reg[WORD_W-1];
    assign do_issue  = cmd.issue && (pool_cnt_reg < pools_open_reg) && !match_now;
    assign match_now = rd_vld_reg &&
                       ((cmd_reg == CMD_ALLOC) ? !rd_busy
                                               : (rd_busy && rd_word_reg[KEY_W-1:0] == key_reg));

    assign stat.clear_last = (clr_cnt_reg == AW'(TOTAL - 1));
    assign stat.match      = match_now;
    assign stat.exhausted  = (pool_cnt_reg >= pools_open_reg) && !rd_vld_reg;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    // Commit decision
    always_comb begin
        c_wr     = 1'b0;
        c_open   = 1'b0;
        c_status = STAT_NOT_FOUND;
        c_pool   = '0;
        c_slot   = '0;
        c_idx    = f_addr_reg;
        c_word   = '0;
        case (cmd_reg)
            CMD_ALLOC: begin
                c_word = {1'b1, key_reg};
                if (hit_reg) begin
                    c_wr     = 1'b1;
                    c_status = STAT_OK;
                    c_pool   = f_pool_reg;
                    c_slot   = f_slot_reg;
                end else if (pool_cnt_reg < PW'(POOLS)) begin
                    // every open pool is full: open the next one, take its first slot;
                    // the scan leaves the counters at that pool's first entry
                    c_wr     = 1'b1;
                    c_open   = 1'b1;
                    c_status = STAT_OK;
                    c_pool   = pool_cnt_reg;
                    c_idx    = addr_reg[AW-1:0];
                end else begin
                    c_status = STAT_NO_SPACE;
                end
            end
            CMD_FREE: begin
                if (hit_reg) begin
                    c_wr     = 1'b1;
                    c_status = STAT_OK;
                    c_pool   = f_pool_reg;
                    c_slot   = f_slot_reg;
                end
            end
            CMD_LOOKUP: begin
                if (hit_reg) begin
                    c_status = STAT_OK;
                    c_pool   = f_pool_reg;
                    c_slot   = f_slot_reg;
                end
            end
            default: begin
                c_status = STAT_NOT_FOUND;
            end
        endcase
    end

    assign wr_en   = cmd.clear || (cmd.commit && c_wr);
    assign wr_idx  = cmd.clear ? clr_cnt_reg : c_idx;
    assign wr_word = cmd.clear ? '0 : c_word;

    assign pool_wide = 32'(c_pool);
    assign slot_wide = 32'(c_slot);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_word;
        end
        if (do_issue) begin
            rd_word_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            pools_open_reg <= PW'(INIT_OPEN);
            rd_vld_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.commit && c_open) begin
                pools_open_reg <= pools_open_reg + PW'(1);
            end
            rd_vld_reg <= do_issue;
            if (cmd.load) begin
                hit_reg <= 1'b0;
            end else if (cmd.capture) begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan position
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg      <= in_cmd;
            key_reg      <= norm_key(in_key);
            pool_cnt_reg <= '0;
            slot_cnt_reg <= '0;
            addr_reg     <= '0;
        end else if (do_issue) begin
            rd_pool_reg <= pool_cnt_reg;
            rd_slot_reg <= slot_cnt_reg;
            rd_addr_reg <= addr_reg[AW-1:0];
            addr_reg    <= addr_reg + CW'(1);
            if (slot_cnt_reg == SW'(SLOTS_PER_POOL - 1)) begin
                slot_cnt_reg <= '0;
                pool_cnt_reg <= pool_cnt_reg + PW'(1);
            end else begin
                slot_cnt_reg <= slot_cnt_reg + SW'(1);
            end
        end
        if (cmd.capture) begin
            f_pool_reg <= rd_pool_reg;
            f_slot_reg <= rd_slot_reg;
            f_addr_reg <= rd_addr_reg;
        end
        if (cmd.commit) begin
            out_status_reg <= c_status;
            out_pool_reg   <= pool_wide[3:0];
            out_slot_reg   <= slot_wide[3:0];
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_status = out_status_reg;
    assign out_pool   = out_pool_reg;
    assign out_slot   = out_slot_reg;

endmodule

>>> sim/pooled_slot_allocator_with_id_lookup_core_tb.sv
// Self-checking testbench for pooled_slot_allocator_with_id_lookup_core.
// Directed table plus phased random allocate/free/lookup traffic, checked
// against an in-bench slot map. Depends on psa_pkg and the core RTL.
`timescale 1ns / 100ps

module pooled_slot_allocator_with_id_lookup_core_tb;
    import psa_pkg::*;

    localparam int NUM_POOLS       = 16;
    localparam int POOL_SLOTS      = 16;
    localparam int START_POOLS     = 2;
    localparam int SLOT_COUNT      = NUM_POOLS * POOL_SLOTS;
    localparam int KEY_SET         = 24;
    localparam int RANDOM_ITEMS    = 1350;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PRESSURE_CYCLES = 900;
    localparam int DRAIN_CYCLES    = 300;
    localparam int PROBE_ROWS      = 22;
    localparam int MAX_PRINTED     = 40;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] pool;
        logic [3:0] slot;
    } slot_outcome_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic        typed;
        logic [1:0]  status;
        logic [3:0]  pool;
        logic [3:0]  slot;
    } probe_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] slot_key
    logic [1:0]  s_tuser;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [1:0] status, [5:2] pool_number, [9:6] slot_number

    // slot map mirrored from the block
    logic        busy_map [SLOT_COUNT];
    logic [63:0] tag_map  [SLOT_COUNT];
    int          fill_count [NUM_POOLS];
    int          open_pools;

    slot_outcome_t pending_results [$];
    probe_row_t    probe_rows [PROBE_ROWS];
    logic [63:0]   key_base [KEY_SET];
    int            key_len  [KEY_SET];

    int error_count  = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int cmd_count    [4];
    int status_count [4];
    bit quiet_mode   = 1'b0;

    pooled_slot_allocator_with_id_lookup_core #(
        .POOLS          (NUM_POOLS),
        .SLOTS_PER_POOL (POOL_SLOTS),
        .INITIAL_POOLS  (START_POOLS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Keep bytes up to the first zero byte, clear the rest.
    function automatic logic [63:0] strip_key(input logic [63:0] k);
        logic [63:0] r;
        int          b;
        r = '0;
        b = 0;
        while (b < 8 && k[8*b +: 8] != 8'd0) begin
            r[8*b +: 8] = k[8*b +: 8];
            b++;
        end
        return r;
    endfunction

    function automatic void clear_slot_map();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            busy_map[i] = 1'b0;
            tag_map[i]  = '0;
        end
        for (int p = 0; p < NUM_POOLS; p++) begin
            fill_count[p] = 0;
        end
        open_pools = (START_POOLS > NUM_POOLS) ? NUM_POOLS : START_POOLS;
    endfunction

    function automatic slot_outcome_t apply_command(input logic [1:0] cmd,
                                                    input logic [63:0] raw_key);
        slot_outcome_t res;
        logic [63:0]   key;
        int            pick;
        int            idx;
        bit            found;
        res.status = STAT_NOT_FOUND;
        res.pool   = 4'd0;
        res.slot   = 4'd0;
        key        = strip_key(raw_key);
        pick       = -1;
        found      = 1'b0;
        case (cmd)
            CMD_ALLOC: begin
                for (int p = 0; p < open_pools && pick < 0; p++) begin
                    if (fill_count[p] < POOL_SLOTS) begin
                        pick = p;
                    end
                end
                // all open pools full: open the next one if any is left
                if (pick < 0 && open_pools < NUM_POOLS) begin
                    pick = open_pools;
                    open_pools++;
                end
                res.status = STAT_NO_SPACE;
                if (pick >= 0) begin
                    for (int s = 0; s < POOL_SLOTS && !found; s++) begin
                        idx = pick * POOL_SLOTS + s;
                        if (!busy_map[idx]) begin
                            busy_map[idx] = 1'b1;
                            tag_map[idx]  = key;
                            fill_count[pick]++;
                            found      = 1'b1;
                            res.status = STAT_OK;
                            res.pool   = pick[3:0];
                            res.slot   = s[3:0];
                        end
                    end
                end
            end
            CMD_FREE, CMD_LOOKUP: begin
                for (int p = 0; p < open_pools && !found; p++) begin
                    for (int s = 0; s < POOL_SLOTS && !found; s++) begin
                        idx = p * POOL_SLOTS + s;
                        if (busy_map[idx] && tag_map[idx] == key) begin
                            found      = 1'b1;
                            res.status = STAT_OK;
                            res.pool   = p[3:0];
                            res.slot   = s[3:0];
                            if (cmd == CMD_FREE) begin
                                busy_map[idx] = 1'b0;
                                if (fill_count[p] > 0) begin
                                    fill_count[p]--;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Mostly ids from a small set, with garbage after the terminator; some fully random.
    function automatic logic [63:0] make_key();
        logic [63:0] k;
        logic [31:0] rnd;
        int          i;
        if ($urandom_range(0, 99) < 15) begin
            return {$urandom, $urandom};
        end
        i = $urandom_range(0, KEY_SET - 1);
        k = key_base[i];
        for (int b = key_len[i] + 1; b < 8; b++) begin
            if ($urandom_range(0, 1) == 1) begin
                rnd = $urandom;
                k[8*b +: 8] = rnd[7:0];
            end
        end
        return k;
    endfunction

    function automatic logic [1:0] pick_cmd(input int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            0: begin
                if (r < 80) return CMD_ALLOC;
                if (r < 88) return CMD_FREE;
                if (r < 96) return CMD_LOOKUP;
            end
            1: begin
                if (r < 12) return CMD_ALLOC;
                if (r < 62) return CMD_FREE;
                if (r < 94) return CMD_LOOKUP;
            end
            default: begin
                if (r < 40) return CMD_ALLOC;
                if (r < 70) return CMD_FREE;
                if (r < 95) return CMD_LOOKUP;
            end
        endcase
        return CMD_UNUSED;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    task automatic report_mismatch(input string field, input int item,
                                   input logic [3:0] got, input logic [3:0] want);
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] result %0d: %s got %0d want %0d", $time, item, field, got, want);
        end
        error_count++;
    endtask

    task automatic offer_command(input logic [1:0] cmd, input logic [63:0] key,
                                 input logic typed, input slot_outcome_t want);
        slot_outcome_t predicted;
        int            gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = apply_command(cmd, key);
        pending_results.push_back(typed ? want : predicted);
        cmd_count[cmd]++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // result checker and activity counter for the watchdog
    always @(posedge aclk) begin : check_results
        slot_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", results_seen,
                                {2'b00, m_tdata[1:0]}, 4'd0);
            end else begin
                want = pending_results.pop_front();
                status_count[want.status]++;
                if (m_tdata[1:0] !== want.status) begin
                    report_mismatch("status", results_seen, {2'b00, m_tdata[1:0]},
                                    {2'b00, want.status});
                end
                if (m_tdata[5:2] !== want.pool) begin
                    report_mismatch("pool_number", results_seen, m_tdata[5:2], want.pool);
                end
                if (m_tdata[9:6] !== want.slot) begin
                    report_mismatch("slot_number", results_seen, m_tdata[9:6], want.slot);
                end
            end
            results_seen++;
            idle_cycles <= 0;
        end else if (aresetn && s_tvalid && s_tready) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial begin : result_sink
        int stall_left;
        bit pressure_done;
        int r;
        stall_left    = 0;
        pressure_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            if (!pressure_done && results_seen >= 200) begin
                stall_left    = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet_mode) begin
                    r = $urandom_range(0, 99);
                    if (r < 65) stall_left = 0;
                    else if (r < 92) stall_left = $urandom_range(1, 3);
                    else if (r < 99) stall_left = $urandom_range(4, 15);
                    else stall_left = $urandom_range(40, 120);
                end
            end
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic [31:0] rnd;
        int          phase;
        for (int c = 0; c < 4; c++) begin
            cmd_count[c]    = 0;
            status_count[c] = 0;
        end
        probe_rows = '{
            '{CMD_LOOKUP, 64'h1,                  1'b1, STAT_NOT_FOUND, 4'd0, 4'd0},
            '{CMD_FREE,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_NOT_FOUND, 4'd0, 4'd0},
            '{CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_NOT_FOUND, 4'd0, 4'd0},
            '{CMD_UNUSED, 64'h0,                  1'b1, STAT_NOT_FOUND, 4'd0, 4'd0},
            '{CMD_ALLOC,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_OK,        4'd0, 4'd0},
            '{CMD_ALLOC,  64'h0,                  1'b1, STAT_OK,        4'd0, 4'd1},
            '{CMD_ALLOC,  64'h41,                 1'b1, STAT_OK,        4'd0, 4'd2},
            // bytes after the terminator must not matter
            '{CMD_LOOKUP, 64'hFFFF_FFFF_FF00_0041, 1'b0, STAT_OK,        4'd0, 4'd0},
            '{CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, STAT_OK,        4'd0, 4'd0},
            // duplicate id: first busy match wins
            '{CMD_ALLOC,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_OK,        4'd0, 4'd3},
            '{CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_OK,        4'd0, 4'd0},
            '{CMD_FREE,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_OK,        4'd0, 4'd0},
            '{CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_OK,        4'd0, 4'd3},
            '{CMD_ALLOC,  64'h8000_0000_0000_0001, 1'b1, STAT_OK,        4'd0, 4'd0},
            '{CMD_LOOKUP, 64'h1,                  1'b0, STAT_OK,        4'd0, 4'd0},
            '{CMD_FREE,   64'h1234,               1'b1, STAT_NOT_FOUND, 4'd0, 4'd0},
            '{CMD_FREE,   64'h0,                  1'b0, STAT_OK,        4'd0, 4'd0},
            '{CMD_FREE,   64'h0,                  1'b0, STAT_OK,        4'd0, 4'd0},
            '{CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, 1'b0, STAT_OK,        4'd0, 4'd0},
            '{CMD_ALLOC,  64'h0123_4567_89AB_CDEF, 1'b0, STAT_OK,        4'd0, 4'd0},
            '{CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, 1'b0, STAT_OK,        4'd0, 4'd0},
            '{CMD_LOOKUP, 64'h0023_4567_89AB_CDEF, 1'b0, STAT_OK,        4'd0, 4'd0}
        };
        // id set: one empty id, one full 8-byte id, the rest random length
        for (int i = 0; i < KEY_SET; i++) begin
            key_len[i]  = (i == 0) ? 0 : (i == 1) ? 8 : $urandom_range(1, 8);
            key_base[i] = '0;
            for (int b = 0; b < key_len[i]; b++) begin
                rnd = $urandom_range(1, 255);
                key_base[i][8*b +: 8] = rnd[7:0];
            end
        end

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        clear_slot_map();

        for (int i = 0; i < PROBE_ROWS; i++) begin
            offer_command(probe_rows[i].cmd, probe_rows[i].key, probe_rows[i].typed,
                          '{probe_rows[i].status, probe_rows[i].pool, probe_rows[i].slot});
        end

        // fill until out of space, drain, then mixed traffic
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_mode = ((n / 150) % 4) == 2;
            phase      = (n < 500) ? 0 : (n < 950) ? 1 : 2;
            offer_command(pick_cmd(phase), make_key(), 1'b0, '0);
        end
        s_tvalid   <= 1'b0;
        quiet_mode = 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("items: %0d alloc, %0d free, %0d lookup, %0d unused code; pools opened: %0d",
                 cmd_count[CMD_ALLOC], cmd_count[CMD_FREE], cmd_count[CMD_LOOKUP],
                 cmd_count[CMD_UNUSED], open_pools);
        $display("results: %0d ok, %0d out of space, %0d not found; %0d mismatches",
                 status_count[STAT_OK], status_count[STAT_NO_SPACE],
                 status_count[STAT_NOT_FOUND], error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
